// File: rtl/ptdt_pkg.sv
// Shared types and constants of the periodic task dispatch table.
package ptdt_pkg;

  localparam int RATE_W = 8;
  localparam int CNT_W  = 8;
  localparam int SLOT_W = 4;

  localparam logic [CNT_W-1:0] RELOAD_RESET = 8'd60;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_REGISTER = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic CFG_TICK_RELOAD   = 1'b0;
  localparam logic CFG_SECOND_RELOAD = 1'b1;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              fired;
    logic              table_full;
    logic              last;
  } result_t;

endpackage

// File: rtl/ptdt_modu.sv
// Shared restoring modulo unit: one quotient bit per cycle, reports a zero remainder.
module ptdt_modu
  import ptdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(RATE_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              zero_r, zero_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0] div_r, div_nxt;
  logic [RATE_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    trial    = {rem_r, quo_r[RATE_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = RATE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[RATE_W-1:0];
      end
      quo_nxt  = {quo_r[RATE_W-2:0], 1'b0};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(RATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        zero_nxt = (rem_nxt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;

endmodule

// File: rtl/periodic_task_dispatch_table.sv
// Top level of the periodic task dispatch table: sequencer, rate memory and counters.
//
// Input beats carry the opcode in in_tuser and two rates in in_tdata. A clear
// beat empties the table and gives no result. A register beat appends a task
// and gives one result beat with the slot assigned, or table_full when all
// slots are taken. A tick beat scans the occupied slots in order and gives one
// result beat per slot whose second rate divides the second counter and whose
// tick rate divides the tick counter; tlast marks the final beat. If no slot
// fires, a single beat with fired low is given. fired and table_full travel in
// out_tuser. The counters advance after the scan. Opcode 3 is dropped.
// A tick walks the slots through the one shared modulo unit: a slot with a
// zero rate is skipped without a test, and the tick test runs only when the
// second test passes; an earlier hit is sent out when a later one is found.
// in_tready is high only while the block is idle. One output register holds
// each result beat; the scan holds at a result beat while that register is full
// and out_tready is low. Reset empties the table, clears both counters and sets
// both reload registers to 60; no clearing pass is needed. The user must write the
// reload registers through cfg_* only while idle; the block does not enforce it.
module periodic_task_dispatch_table
  import ptdt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tick_rate[7:0], second_rate[15:8]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // slot[3:0], zero pad
  output logic [1:0]  out_tuser,  // fired[0], table_full[1]
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_MODS, S_MODT, S_PUSH, S_NEXT, S_FIN, S_REGO
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      entry_r, entry_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [CNT_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [CNT_W-1:0]   sec_cnt_r, sec_cnt_nxt;
  logic [CNT_W-1:0]   tick_rel_r, tick_rel_nxt;
  logic [CNT_W-1:0]   sec_rel_r, sec_rel_nxt;
  result_t            res_r, res_nxt;
  logic               out_v_r, out_v_nxt;
  result_t            out_res_r, out_res_nxt;

  logic [2*RATE_W-1:0] rate_mem [SLOTS];
  logic [2*RATE_W-1:0] rd_q_r;
  logic                mem_we;

  logic               in_fire, out_free;
  logic [1:0]         op;
  logic [RATE_W-1:0]  in_trate, in_srate, rd_tr, rd_sr;
  logic [CNT_W-1:0]   tc_dec, sc_inc;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  ptdt_modu u_modu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;
  assign op        = in_tuser;
  assign in_trate  = in_tdata[7:0];
  assign in_srate  = in_tdata[15:8];
  assign rd_tr     = rd_q_r[RATE_W-1:0];
  assign rd_sr     = rd_q_r[2*RATE_W-1:RATE_W];
  assign mem_we    = in_fire && (op == OP_REGISTER) && (entry_r < CW'(SLOTS));
  assign tc_dec    = tick_cnt_r - CNT_W'(1);
  assign sc_inc    = sec_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rate_mem[entry_r[SW-1:0]] <= {in_srate, in_trate};
    end
    rd_q_r <= rate_mem[scan_r[SW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    scan_nxt      = scan_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    tick_cnt_nxt  = tick_cnt_r;
    sec_cnt_nxt   = sec_cnt_r;
    tick_rel_nxt  = tick_rel_r;
    sec_rel_nxt   = sec_rel_r;
    res_nxt       = res_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_res_nxt   = out_res_r;
    mod_req       = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RELOAD:   tick_rel_nxt = cfg_wdata;
        CFG_SECOND_RELOAD: sec_rel_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_CLEAR: entry_nxt = '0;
            OP_REGISTER: begin
              if (entry_r < CW'(SLOTS)) begin
                res_nxt   = '{slot: SLOT_W'(entry_r), fired: 1'b0, table_full: 1'b0,
                              last: 1'b1};
                entry_nxt = entry_r + CW'(1);
              end else begin
                res_nxt = '{slot: '0, fired: 1'b0, table_full: 1'b1, last: 1'b1};
              end
              state_nxt = S_REGO;
            end
            OP_TICK: begin
              scan_nxt   = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_NEXT;
            end
            default: ;
          endcase
        end
      end
      S_NEXT: begin
        if (scan_r == entry_r) begin
          if (pend_v_r) begin
            res_nxt = '{slot: pend_slot_r, fired: 1'b1, table_full: 1'b0, last: 1'b1};
          end else begin
            res_nxt = '{slot: '0, fired: 1'b0, table_full: 1'b0, last: 1'b1};
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (rd_tr == '0 || rd_sr == '0) begin
          scan_nxt  = scan_r + CW'(1);
          state_nxt = S_NEXT;
        end else begin
          mod_req   = '{start: 1'b1, dividend: sec_cnt_r, divisor: rd_sr};
          state_nxt = S_MODS;
        end
      end
      S_MODS: begin
        if (mod_rsp.done) begin
          if (mod_rsp.zero) begin
            mod_req   = '{start: 1'b1, dividend: tick_cnt_r, divisor: rd_tr};
            state_nxt = S_MODT;
          end else begin
            scan_nxt  = scan_r + CW'(1);
            state_nxt = S_NEXT;
          end
        end
      end
      S_MODT: begin
        if (mod_rsp.done) begin
          if (!mod_rsp.zero) begin
            scan_nxt  = scan_r + CW'(1);
            state_nxt = S_NEXT;
          end else if (pend_v_r) begin
            // earlier hit is not the last one: send it before holding this one
            res_nxt   = '{slot: pend_slot_r, fired: 1'b1, table_full: 1'b0, last: 1'b0};
            state_nxt = S_PUSH;
          end else begin
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = SLOT_W'(scan_r);
            scan_nxt      = scan_r + CW'(1);
            state_nxt     = S_NEXT;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_v_nxt     = 1'b1;
          out_res_nxt   = res_r;
          pend_slot_nxt = SLOT_W'(scan_r);
          scan_nxt      = scan_r + CW'(1);
          state_nxt     = S_NEXT;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_res_nxt = res_r;
          // advance the tick counter, reload and roll the second counter on zero
          if (tc_dec == '0) begin
            tick_cnt_nxt = tick_rel_r;
            sec_cnt_nxt  = (sc_inc == '0) ? sec_rel_r : sc_inc;
          end else begin
            tick_cnt_nxt = tc_dec;
          end
          state_nxt = S_IDLE;
        end
      end
      S_REGO: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_res_nxt = res_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      entry_r    <= '0;
      scan_r     <= '0;
      pend_v_r   <= 1'b0;
      tick_cnt_r <= '0;
      sec_cnt_r  <= '0;
      tick_rel_r <= RELOAD_RESET;
      sec_rel_r  <= RELOAD_RESET;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      entry_r    <= entry_nxt;
      scan_r     <= scan_nxt;
      pend_v_r   <= pend_v_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      sec_cnt_r  <= sec_cnt_nxt;
      tick_rel_r <= tick_rel_nxt;
      sec_rel_r  <= sec_rel_nxt;
      out_v_r    <= out_v_nxt;
    end
    pend_slot_r <= pend_slot_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_res_r.slot};
  assign out_tuser  = {out_res_r.table_full, out_res_r.fired};
  assign out_tlast  = out_res_r.last;

`ifndef ASSERT_OFF
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_r <= CW'(SLOTS))
    else $error("entry count exceeds slot count");

  a_mod_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MODS || state_r == S_MODT))
    else $error("modulo result arrived outside the scan");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_CLEAR) |=> (entry_r == '0))
    else $error("clear did not empty the table");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_REGO) |-> (scan_r <= entry_r))
    else $error("scan index ran past the occupied slots");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the periodic task dispatch table: directed and random beats against a predictor.
module tb_top;
  import ptdt_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int unsigned LIMIT = 2_000_000;

  localparam logic [7:0] DIR_TICK_RATE [16] =
    '{8'd1, 8'd255, 8'd3, 8'd5, 8'd15, 8'd17, 8'd85, 8'd51,
      8'd2, 8'd1, 8'd255, 8'd1, 8'd4, 8'd128, 8'd1, 8'd7};
  localparam logic [7:0] DIR_SEC_RATE [16] =
    '{8'd1, 8'd255, 8'd2, 8'd128, 8'd1, 8'd1, 8'd3, 8'd1,
      8'd1, 8'd7, 8'd1, 8'd255, 8'd1, 8'd1, 8'd64, 8'd1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // tick_rate[7:0], second_rate[15:8]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // slot[3:0], zero pad
  logic [1:0]  out_tuser;       // fired[0], table_full[1]
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  periodic_task_dispatch_table #(.SLOTS(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted state of the table and its counters
  logic [7:0]  tick_div [SLOTS];
  logic [7:0]  sec_div [SLOTS];
  int unsigned n_tasks = 0;
  logic [7:0]  tick_cnt = '0;
  logic [7:0]  sec_cnt = '0;
  logic [7:0]  tick_rld = RELOAD_RESET;
  logic [7:0]  sec_rld = RELOAD_RESET;

  result_t     due_q [$];
  logic [17:0] pend_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned ticks_queued = 0;
  logic        in_acc = 1'b0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  initial forever #10 clk = ~clk;

  // Work out the result beats one accepted input beat causes and advance the counters.
  task automatic dispatch_beat(input logic [17:0] beat);
    logic [1:0] op;
    logic [7:0] tr;
    logic [7:0] sr;
    result_t    r;
    int         n_fired;
    int         i;
    op = beat[1:0];
    tr = beat[9:2];
    sr = beat[17:10];
    n_fired = 0;
    case (op)
      OP_CLEAR: n_tasks = 0;
      OP_REGISTER: begin
        r = '0;
        r.last = 1'b1;
        if (n_tasks < SLOTS) begin
          tick_div[n_tasks] = tr;
          sec_div[n_tasks] = sr;
          r.slot = n_tasks[SLOT_W-1:0];
          n_tasks++;
        end else begin
          r.table_full = 1'b1;
        end
        due_q.push_back(r);
      end
      OP_TICK: begin
        for (i = 0; i < n_tasks; i++) begin
          if (tick_div[i] != 8'd0 && sec_div[i] != 8'd0 &&
              (sec_cnt % sec_div[i]) == 8'd0 && (tick_cnt % tick_div[i]) == 8'd0) begin
            r = '0;
            r.slot = i[SLOT_W-1:0];
            r.fired = 1'b1;
            due_q.push_back(r);
            n_fired++;
          end
        end
        if (n_fired == 0) begin
          r = '0;
          r.last = 1'b1;
        end else begin
          r = due_q.pop_back();
          r.last = 1'b1;
        end
        due_q.push_back(r);
        tick_cnt = tick_cnt - 8'd1;
        if (tick_cnt == 8'd0) begin
          tick_cnt = tick_rld;
          sec_cnt = sec_cnt + 8'd1;
          if (sec_cnt == 8'd0) sec_cnt = sec_rld;
        end
      end
      default: ;
    endcase
  endtask

  // Predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (!rst_n) begin
      n_tasks = 0;
      tick_cnt = '0;
      sec_cnt = '0;
      tick_rld = RELOAD_RESET;
      sec_rld = RELOAD_RESET;
      in_acc <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TICK_RELOAD) tick_rld = cfg_wdata;
        else sec_rld = cfg_wdata;
      end
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) dispatch_beat({in_tdata, in_tuser});
      if (out_tvalid && out_tready) begin
        got.slot = out_tdata[3:0];
        got.fired = out_tuser[0];
        got.table_full = out_tuser[1];
        got.last = out_tlast;
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: slot %0d fired %0b full %0b last %0b",
                   $time, got.slot, got.fired, got.table_full, got.last);
        end else begin
          want = due_q.pop_front();
          if (got.slot !== want.slot || got.fired !== want.fired ||
              got.table_full !== want.table_full || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected slot %0d fired %0b full %0b last %0b, %s%0d %0b %0b %0b",
                     $time, want.slot, want.fired, want.table_full, want.last,
                     "got slot/fired/full/last ", got.slot, got.fired, got.table_full, got.last);
          end
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, due_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Input driver: hold a beat until taken, idle now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
        in_tvalid <= 1'b1;
        {in_tdata, in_tuser} <= pend_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (calm || $urandom_range(99) >= 9);
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [7:0] tr, input logic [7:0] sr);
    pend_q.push_back({sr, tr, op});
    if (op == OP_TICK) ticks_queued++;
  endtask

  function automatic logic [7:0] pick_rate();
    int unsigned p;
    logic [7:0]  rate;
    p = $urandom_range(99);
    if (p < 12) rate = 8'd0;
    else if (p < 60) rate = 8'($urandom_range(4, 1));
    else if (p < 75) rate = 8'($urandom_range(16, 5));
    else rate = 8'($urandom_range(255, 0));
    return rate;
  endfunction

  // Queue random beats until both the item count and the tick goal are met
  task automatic random_phase(input int tick_pct, input int unsigned tick_goal, input int count);
    int          n;
    int unsigned p;
    int unsigned q;
    n = 0;
    while (n < count || ticks_queued < tick_goal) begin
      p = $urandom_range(99);
      q = $urandom_range(99);
      if (p < tick_pct) begin
        queue_item(OP_TICK, pick_rate(), pick_rate());
        n++;
      end else if (q < 70) begin
        queue_item(OP_REGISTER, pick_rate(), pick_rate());
        n++;
      end else if (q < 85) begin
        queue_item(OP_CLEAR, pick_rate(), pick_rate());
        n++;
      end else begin
        queue_item(OP_UNUSED, pick_rate(), pick_rate());
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pend_q.size() != 0 || in_tvalid);
    do @(negedge clk); while (due_q.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reload(input logic idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    int k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dropped opcode, full table, all slots firing, zero rates, empty tick
    queue_item(OP_UNUSED, 8'hFF, 8'hFF);
    for (k = 0; k < SLOTS; k++) queue_item(OP_REGISTER, DIR_TICK_RATE[k], DIR_SEC_RATE[k]);
    queue_item(OP_REGISTER, 8'hFF, 8'hFF);
    queue_item(OP_TICK, 8'h00, 8'h00);
    queue_item(OP_TICK, 8'hFF, 8'hFF);
    queue_item(OP_CLEAR, 8'h00, 8'h00);
    queue_item(OP_REGISTER, 8'd0, 8'd1);
    queue_item(OP_REGISTER, 8'd1, 8'd0);
    queue_item(OP_REGISTER, 8'd1, 8'd1);
    queue_item(OP_TICK, 8'h00, 8'h00);
    queue_item(OP_CLEAR, 8'hFF, 8'hFF);
    queue_item(OP_TICK, 8'h00, 8'h00);
    wait_idle();

    // Run the tick counter down to its first reload, with one long output stall
    write_reload(CFG_TICK_RELOAD, 8'd2);
    write_reload(CFG_SECOND_RELOAD, 8'd255);
    @(posedge clk);
    random_phase(90, 262, 0);
    hold_req = 1'b1;
    wait_idle();

    // Reload every tick so the second counter advances on each tick
    write_reload(CFG_TICK_RELOAD, 8'd1);
    write_reload(CFG_SECOND_RELOAD, 8'd255);
    @(posedge clk);
    goal = ticks_queued + 16;
    random_phase(85, goal, 0);
    wait_idle();

    // Zero reloads, no idling on either side
    write_reload(CFG_TICK_RELOAD, 8'd0);
    write_reload(CFG_SECOND_RELOAD, 8'd0);
    @(posedge clk);
    calm = 1'b1;
    random_phase(50, 0, 20);
    wait_idle();

    write_reload(CFG_TICK_RELOAD, 8'd255);
    write_reload(CFG_SECOND_RELOAD, 8'd1);
    @(posedge clk);
    calm = 1'b0;
    random_phase(60, 0, 8);
    wait_idle();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ptdt_pkg.sv
rtl/ptdt_modu.sv
rtl/periodic_task_dispatch_table.sv
tb/tb_top.sv
